/* rtl/psif_pkg.sv */
package psif_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int BUCKETS = 16;
	localparam int POS_W = $clog2(MAX_ITEMS);
	localparam int CNT_W = POS_W + 1;
	localparam int HASH_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NUM_HEADS = 1 << HASH_W;
	localparam int FIELD_POS_W = 10;

	typedef enum logic [2:0] {
		ST_PENDING = 3'd0,
		ST_FOUND   = 3'd1,
		ST_NONE    = 3'd2,
		ST_IGNORED = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               start_req;
		logic               last;
	} item_t;

	typedef struct packed {
		status_t                  status;
		logic [FIELD_POS_W-1:0]   earlier_position;
		logic [FIELD_POS_W-1:0]   current_position;
	} result_t;

	function automatic logic [HASH_W-1:0] key_hash(input logic [31:0] key);
		logic [HASH_W-1:0] h;
		h = '0;
		for (int i = 0; i < 32; i++) begin
			h[i % HASH_W] = h[i % HASH_W] ^ key[i];
		end
		return h;
	endfunction

endpackage

/* rtl/pair_sum_index_finder_unit.sv */
// Pair-sum index finder.
// item channel (item_valid / item_stall / item): one array element per
// transaction; start_req opens a new array, last closes it.
// result channel (result_valid / result_stall / result): exactly one result
// per item, in order: status, earlier position on a hit, current position.
// cfg_we / cfg_wdata write target_sum; write only while the block is idle.
// Each element is hashed into one of BUCKETS chains kept in an entry memory
// (one read and one write port); newest entries sit at the chain head so the
// latest equal key shadows older ones.
// Steps: an element that does a lookup goes through S_PROBE, then S_CMP for
// each chain entry visited (one per cycle through the entry memory read
// port), then S_DONE, which loads the result register. Ignored and
// over-capacity elements go from acceptance straight to S_DONE. One element
// is in work at a time; item_stall is high from acceptance until the result
// is registered; the next item is taken once the block is back in S_IDLE.
// The result register holds a valid result while result_stall is high; a
// finished element then waits in S_DONE and the next item is not taken.
// Reset: target_sum is 0, all chains empty, position count 0. No clearing
// pass: the memory is only read along chains built in the current array.
module pair_sum_index_finder_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  psif_pkg::item_t        item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output psif_pkg::result_t      result,
	input  logic                   cfg_we,
	input  logic [31:0]            cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PROBE = 4'b0010,
		S_CMP   = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	typedef struct packed {
		logic [31:0]                   key;
		logic                          link_valid;
		logic [psif_pkg::POS_W-1:0]    link;
	} entry_t;

	state_t state_q;

	logic [31:0] target_q;
	logic [psif_pkg::CNT_W-1:0] count_q;
	logic answered_q;

	logic [31:0] value_q;
	logic last_q;
	logic [psif_pkg::CNT_W-1:0] pos_q;
	logic [31:0] comp_q;
	logic comp_ok_q;
	logic [psif_pkg::HASH_W-1:0] hash_c_q;
	logic [psif_pkg::HASH_W-1:0] hash_v_q;
	psif_pkg::status_t status_q;
	logic [psif_pkg::POS_W-1:0] earlier_q;
	logic store_q;
	logic [psif_pkg::POS_W-1:0] ptr_q;

	logic [psif_pkg::POS_W-1:0] heads_q [psif_pkg::NUM_HEADS];
	logic [psif_pkg::NUM_HEADS-1:0] head_valid_q;

	entry_t mem [psif_pkg::MAX_ITEMS];
	entry_t rdata_q;

	logic res_valid_q;
	psif_pkg::result_t result_q;

	logic item_acc;
	logic res_load;
	logic [psif_pkg::CNT_W-1:0] eff_pos;
	logic eff_ans;
	logic [32:0] comp;
	logic [psif_pkg::HASH_W-1:0] head_idx;
	logic [psif_pkg::POS_W-1:0] head_rd;
	logic [psif_pkg::POS_W-1:0] rd_addr;
	logic mem_we;
	logic [psif_pkg::FIELD_POS_W-1:0] cur_pos;
	psif_pkg::status_t miss_status;

	assign item_stall = (state_q != S_IDLE);
	assign item_acc = item_valid && !item_stall;
	assign res_load = (state_q == S_DONE) && (!res_valid_q || !result_stall);
	assign mem_we = res_load && store_q;

	assign eff_pos = item.start_req ? '0 : count_q;
	assign eff_ans = item.start_req ? 1'b0 : answered_q;
	assign comp = {target_q[31], target_q} - {item.value[31], item.value};

	assign head_idx = (state_q == S_DONE) ? hash_v_q : hash_c_q;
	assign head_rd = heads_q[head_idx];
	assign rd_addr = (state_q == S_PROBE) ? head_rd : rdata_q.link;

	assign miss_status = last_q ? psif_pkg::ST_NONE : psif_pkg::ST_PENDING;
	assign cur_pos = (pos_q >= psif_pkg::CNT_W'(psif_pkg::MAX_ITEMS))
		? {psif_pkg::FIELD_POS_W{1'b1}} : psif_pkg::FIELD_POS_W'(pos_q);

	assign result_valid = res_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (cfg_we) begin
			target_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			answered_q <= 1'b0;
			head_valid_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						if (item.start_req) begin
							head_valid_q <= '0;
						end
						count_q <= (eff_pos < psif_pkg::CNT_W'(psif_pkg::MAX_ITEMS))
							? eff_pos + 1'b1 : eff_pos;
						if (eff_ans) begin
							answered_q <= 1'b1;
							state_q <= S_DONE;
						end else if (eff_pos >= psif_pkg::CNT_W'(psif_pkg::MAX_ITEMS)) begin
							answered_q <= item.last;
							state_q <= S_DONE;
						end else begin
							answered_q <= 1'b0;
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (comp_ok_q && head_valid_q[hash_c_q]) begin
						state_q <= S_CMP;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CMP: begin
					if (rdata_q.key == comp_q || !rdata_q.link_valid) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						if (status_q == psif_pkg::ST_FOUND || status_q == psif_pkg::ST_NONE) begin
							answered_q <= 1'b1;
						end
						if (store_q) begin
							head_valid_q[hash_v_q] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Per-item working registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					value_q <= item.value;
					last_q <= item.last;
					pos_q <= eff_pos;
					comp_q <= comp[31:0];
					comp_ok_q <= (comp[32] == comp[31]);
					hash_c_q <= psif_pkg::key_hash(comp[31:0]);
					hash_v_q <= psif_pkg::key_hash(item.value);
					earlier_q <= '0;
					store_q <= 1'b0;
					if (eff_ans) begin
						status_q <= psif_pkg::ST_IGNORED;
					end else begin
						status_q <= psif_pkg::ST_FULL;
					end
				end
			end
			S_PROBE: begin
				ptr_q <= head_rd;
				if (!(comp_ok_q && head_valid_q[hash_c_q])) begin
					status_q <= miss_status;
					store_q <= 1'b1;
				end
			end
			S_CMP: begin
				if (rdata_q.key == comp_q) begin
					status_q <= psif_pkg::ST_FOUND;
					earlier_q <= ptr_q;
				end else if (rdata_q.link_valid) begin
					ptr_q <= rdata_q.link;
				end else begin
					status_q <= miss_status;
					store_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			heads_q[hash_v_q] <= pos_q[psif_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[pos_q[psif_pkg::POS_W-1:0]] <= '{key: value_q,
				link_valid: head_valid_q[hash_v_q], link: head_rd};
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q.status <= status_q;
			result_q.earlier_position <= psif_pkg::FIELD_POS_W'(earlier_q);
			result_q.current_position <= cur_pos;
		end
	end

	a_walk_in_array: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> ({1'b0, ptr_q} < pos_q))
		else $error("chain walk reached an entry not written in this array");

	a_found_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && status_q == psif_pkg::ST_FOUND) |=> answered_q)
		else $error("pair found but array not closed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= psif_pkg::CNT_W'(psif_pkg::MAX_ITEMS))
		else $error("position count beyond capacity");

	a_busy_until_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc) |=> (item_stall && !$rose(res_valid_q)))
		else $error("item finished without a lookup step");

endmodule
